FILE: hw/rtl/rvps_pkg.sv
// Package: shared types, constants and command structs for the position sizer.
`timescale 1ns / 1ps
package rvps_pkg;

   localparam int QOne  = 65536;
   localparam int QHalf = 32768;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_HURST_CEILING = 3'd0,
      REG_FACTOR_NEUTRAL = 3'd1,
      REG_FACTOR_HIGH   = 3'd2,
      REG_FACTOR_LOW    = 3'd3,
      REG_VOL_TARGET    = 3'd4,
      REG_VOL_FLOOR     = 3'd5,
      REG_VOL_CAP       = 3'd6,
      REG_CHANGE_RATIO  = 3'd7
   } reg_index_type;

   localparam logic CMD_HURST = 1'b0;
   localparam logic CMD_VOL   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REGIME,
      ST_RDIV,
      ST_VDIV,
      ST_VCLAMP,
      ST_MULT,
      ST_CHG_A,
      ST_CHG_B,
      ST_COMMIT,
      ST_OUT
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture input item and start
      logic regime;     // evaluate regime cases, prepare division
      logic rdiv_start;
      logic vdiv_start;
      logic div_step;
      logic vclamp;
      logic mult;
      logic chg_a;
      logic chg_b;
      logic commit;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic div_done;
      logic rdiv_needed;
      logic vdiv_needed;
   } status_type;

   localparam int DivBits = 48;
   localparam logic [5:0] DivSteps = 6'(DivBits);

endpackage

FILE: hw/rtl/regime_vol_position_sizer_core.sv
// Top level: regime and volatility aware position size multiplier.
`timescale 1ns / 1ps
// Usage:
//  The req channel carries one item: tuser = command (0 Hurst, 1 volatility),
//  tdata = signed Q16.16 sample. The rsp channel returns one item per
//  accepted update with the new multiplier, prior multiplier, factors, change
//  flag and wrapping counters. A volatility item with a sample of zero or below
//  is accepted and dropped: no result.
//  The csr channel writes register csr_index with csr_data; any valid index
//  also clears the held state. Write only while idle.
//  The shared restoring divider (Hurst at or above 0.5 and below the ceiling,
//  and target over a positive volatility with a nonzero target) runs 48
//  one-bit steps per division. One item in flight; the next item can be
//  taken in the cycle after the result is delivered. Reset restores all
//  register defaults and the held state but the previous multiplier and
//  change flag. If rsp_tready is low the result holds and no new item is
//  taken until it is delivered.
module regime_vol_position_sizer_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] sample_value
   input  logic         req_tuser,   // [0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [24:0] multiplier, [49:25] previous_multiplier, [68:50] regime_out,
   // [91:69] vol_scale_out, [123:92] update_total, [155:124] change_total
   output logic [159:0] rsp_tdata,
   output logic         rsp_tuser,   // [0] size_changed
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   rvps_pkg::cmd_type    cmd;
   rvps_pkg::status_type status;
   logic [24:0] sm, pm;
   logic [18:0] ro;
   logic [22:0] vo;
   logic [31:0] ut, ct;

   assign csr_ready = 1'b1;

   rvps_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_cmd(req_tuser), .req_sample_pos(!req_tdata[31] && req_tdata != 32'd0),
      .rsp_tvalid, .rsp_tready, .cmd, .status
   );

   rvps_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_cmd(req_tuser), .req_sample(req_tdata),
      .csr_we(csr_valid), .csr_index, .csr_data,
      .mult_out(sm), .previous_multiplier(pm), .regime_out(ro),
      .vol_scale_out(vo), .size_changed(rsp_tuser),
      .update_total(ut), .change_total(ct)
   );

   assign rsp_tdata = {4'd0, ct, ut, vo, ro, pm, sm};

endmodule

FILE: hw/rtl/rvps_ctrl.sv
// Controller: sequences one item through regime, division, multiply and change test.
`timescale 1ns / 1ps
module rvps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_cmd,
   input  logic                   req_sample_pos,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output rvps_pkg::cmd_type      cmd,
   input  rvps_pkg::status_type   status
);

   rvps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rvps_pkg::ST_IDLE: begin
            if (req_tvalid && !(req_cmd == rvps_pkg::CMD_VOL && !req_sample_pos)) begin
               state_in = rvps_pkg::ST_REGIME;
            end
         end
         rvps_pkg::ST_REGIME: begin
            if (status.rdiv_needed) state_in = rvps_pkg::ST_RDIV;
            else if (status.vdiv_needed) state_in = rvps_pkg::ST_VDIV;
            else state_in = rvps_pkg::ST_VCLAMP;
         end
         rvps_pkg::ST_RDIV: begin
            if (status.div_done) begin
               state_in = status.vdiv_needed ? rvps_pkg::ST_VDIV : rvps_pkg::ST_VCLAMP;
            end
         end
         rvps_pkg::ST_VDIV: if (status.div_done) state_in = rvps_pkg::ST_VCLAMP;
         rvps_pkg::ST_VCLAMP: state_in = rvps_pkg::ST_MULT;
         rvps_pkg::ST_MULT:   state_in = rvps_pkg::ST_CHG_A;
         rvps_pkg::ST_CHG_A:  state_in = rvps_pkg::ST_CHG_B;
         rvps_pkg::ST_CHG_B:  state_in = rvps_pkg::ST_COMMIT;
         rvps_pkg::ST_COMMIT: state_in = rvps_pkg::ST_OUT;
         rvps_pkg::ST_OUT:    if (rsp_tready) state_in = rvps_pkg::ST_IDLE;
         default:             state_in = rvps_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         rvps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            // a volatility item of zero or below is taken and dropped
            cmd.load = req_tvalid && !(req_cmd == rvps_pkg::CMD_VOL && !req_sample_pos);
         end
         rvps_pkg::ST_REGIME: begin
            cmd.regime = 1'b1;
            cmd.rdiv_start = status.rdiv_needed;
            cmd.vdiv_start = !status.rdiv_needed && status.vdiv_needed;
         end
         rvps_pkg::ST_RDIV: begin
            cmd.div_step = !status.div_done;
            cmd.vdiv_start = status.div_done && status.vdiv_needed;
         end
         rvps_pkg::ST_VDIV:   cmd.div_step = !status.div_done;
         rvps_pkg::ST_VCLAMP: cmd.vclamp = 1'b1;
         rvps_pkg::ST_MULT:   cmd.mult = 1'b1;
         rvps_pkg::ST_CHG_A:  cmd.chg_a = 1'b1;
         rvps_pkg::ST_CHG_B:  cmd.chg_b = 1'b1;
         rvps_pkg::ST_COMMIT: cmd.commit = 1'b1;
         rvps_pkg::ST_OUT:    rsp_tvalid = 1'b1;
         default:             cmd = '0;
      endcase
   end

   // a result only appears after a commit
   a_out_after_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == rvps_pkg::ST_COMMIT)
      else $error("result without commit");
   // never accept while a result is pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("accept while result pending");
   // one division start at a time
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rdiv_start && cmd.vdiv_start))
      else $error("two divider starts");

endmodule

FILE: hw/rtl/rvps_datapath.sv
// Datapath: held state, shared restoring divider, multiplier and change test.
`timescale 1ns / 1ps
module rvps_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rvps_pkg::cmd_type     cmd,
   output rvps_pkg::status_type  status,
   input  logic                  req_cmd,
   input  logic signed [31:0]    req_sample,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   output logic [24:0]           mult_out,
   output logic [24:0]           previous_multiplier,
   output logic [18:0]           regime_out,
   output logic [22:0]           vol_scale_out,
   output logic                  size_changed,
   output logic [31:0]           update_total,
   output logic [31:0]           change_total
);

   // configuration
   logic [16:0] hurst_ceiling_ff;
   logic [18:0] factor_neutral_ff, factor_high_ff, factor_low_ff;
   logic [30:0] vol_target_ff, change_ratio_ff;
   logic [22:0] vol_floor_ff, vol_cap_ff;

   // held state
   logic signed [31:0] hurst_ff, vol_ff;
   logic [24:0] mult_ff, old_mult_ff;
   logic [18:0] regime_ff;
   logic [22:0] vscale_ff;
   logic [31:0] upd_cnt_ff, chg_cnt_ff;
   logic        changed_ff;

   // working registers
   logic        vdiv_needed;
   logic [18:0] r_base_ff;
   logic        r_neg_ff;
   logic [47:0] vq_ff;
   logic [41:0] prod_ff;
   logic [40:0] lhs_ff;
   logic [55:0] rhs_ff;

   // divider
   logic [47:0] dv_num_ff;
   logic [47:0] dv_rem_ff;
   logic [31:0] dv_den_ff;
   logic [5:0]  dv_cnt_ff;
   logic        dv_busy_ff;
   logic        dv_is_r_ff;
   logic [48:0] dv_trial;
   logic [47:0] dv_rem_sh;
   logic [47:0] dv_quot;

   // regime case evaluation
   logic signed [32:0] h_ext, d_val, span_val;
   logic [18:0] r_a, r_b, r_diff;
   logic        r_neg;
   logic [16:0] r_num;   // d or hurst, below span or 32768
   logic [16:0] r_den;
   logic [18:0] r_const;
   logic        r_use_const;
   logic        r_direct;  // lower half: divide by 0.5 is a shift
   logic [35:0] r_prod;
   logic [18:0] r_lowq;

   always_comb begin
      h_ext    = 33'(hurst_ff);
      d_val    = h_ext - 33'sd32768;
      span_val = 33'($signed({1'b0, hurst_ceiling_ff})) - 33'sd32768;
      r_a = factor_low_ff; r_b = factor_neutral_ff;
      r_num = 17'(hurst_ff[14:0]); r_den = 17'd32768;
      r_const = factor_low_ff; r_use_const = 1'b0; r_direct = 1'b0;
      if (!hurst_ff[31] && hurst_ff >= 32'sd32768) begin
         r_a = factor_neutral_ff; r_b = factor_high_ff;
         r_num = d_val[16:0]; r_den = span_val[16:0];
         if (span_val <= 0) begin
            r_use_const = 1'b1; r_const = factor_neutral_ff;
         end else if (d_val >= span_val) begin
            r_use_const = 1'b1; r_const = factor_high_ff;
         end
      end else if (hurst_ff[31] || hurst_ff == 32'sd0) begin
         r_use_const = 1'b1; r_const = factor_low_ff;
      end else begin
         r_direct = 1'b1;
      end
      r_neg  = r_b < r_a;
      r_diff = r_neg ? r_a - r_b : r_b - r_a;
      r_prod = 36'(r_num) * 36'(r_diff);
      r_lowq = r_prod[33:15];
   end

   assign dv_rem_sh = {dv_rem_ff[46:0], dv_num_ff[47]};
   assign dv_trial  = {1'b0, dv_rem_sh} - {17'd0, dv_den_ff};
   assign dv_quot   = {dv_num_ff[46:0], !dv_trial[48]};

   assign vdiv_needed = (vol_ff > 0) && (vol_target_ff != '0);

   assign status.div_done    = !dv_busy_ff;
   assign status.rdiv_needed = !r_use_const && !r_direct;
   assign status.vdiv_needed = vdiv_needed;

   // cap-then-floor clamp of the quotient
   logic [22:0] vclamped;
   always_comb begin
      logic [47:0] t;
      t = vq_ff;
      if (t > 48'(vol_cap_ff)) t = 48'(vol_cap_ff);
      if (t < 48'(vol_floor_ff)) t = 48'(vol_floor_ff);
      vclamped = t[22:0];
   end

   logic [24:0] mult_sat;
   assign mult_sat = (prod_ff[41:16] > 26'h1FFFFFF) ? 25'h1FFFFFF : prod_ff[40:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         hurst_ceiling_ff  <= 17'd65536;
         factor_neutral_ff <= 19'd65536;
         factor_high_ff    <= 19'd98304;
         factor_low_ff     <= 19'd32768;
         vol_target_ff     <= '0;
         vol_floor_ff      <= 23'd16384;
         vol_cap_ff        <= 23'd131072;
         change_ratio_ff   <= 31'd6554;
      end else if (csr_we) begin
         case (rvps_pkg::reg_index_type'(csr_index))
            rvps_pkg::REG_HURST_CEILING:  hurst_ceiling_ff  <= csr_data[16:0];
            rvps_pkg::REG_FACTOR_NEUTRAL: factor_neutral_ff <= csr_data[18:0];
            rvps_pkg::REG_FACTOR_HIGH:    factor_high_ff    <= csr_data[18:0];
            rvps_pkg::REG_FACTOR_LOW:     factor_low_ff     <= csr_data[18:0];
            rvps_pkg::REG_VOL_TARGET:     vol_target_ff     <= csr_data[30:0];
            rvps_pkg::REG_VOL_FLOOR:      vol_floor_ff      <= csr_data[22:0];
            rvps_pkg::REG_VOL_CAP:        vol_cap_ff        <= csr_data[22:0];
            rvps_pkg::REG_CHANGE_RATIO:   change_ratio_ff   <= csr_data[30:0];
            default:                      vol_target_ff     <= vol_target_ff;
         endcase
      end
   end

   // state and sequencing
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         hurst_ff   <= 32'sd32768;
         vol_ff     <= '0;
         mult_ff    <= 25'd65536;
         regime_ff  <= 19'd65536;
         vscale_ff  <= 23'd65536;
         upd_cnt_ff <= '0;
         chg_cnt_ff <= '0;
         dv_busy_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (req_cmd == rvps_pkg::CMD_VOL) vol_ff <= req_sample;
            else hurst_ff <= req_sample;
            old_mult_ff <= mult_ff;
         end
         if (cmd.regime) begin
            r_base_ff      <= r_use_const ? r_const : r_a;
            r_neg_ff       <= r_neg;
            if (r_use_const) regime_ff <= r_const;
            else if (r_direct) regime_ff <= r_neg ? r_a - r_lowq : r_a + r_lowq;
            vq_ff          <= 48'd65536;
         end
         if (cmd.rdiv_start) begin
            dv_num_ff  <= 48'(r_prod);
            dv_den_ff  <= 32'(r_den);
            dv_rem_ff  <= '0;
            dv_cnt_ff  <= rvps_pkg::DivSteps;
            dv_busy_ff <= 1'b1;
            dv_is_r_ff <= 1'b1;
         end else if (cmd.vdiv_start) begin
            dv_num_ff  <= {1'b0, vol_target_ff, 16'd0};
            dv_den_ff  <= vol_ff;
            dv_rem_ff  <= '0;
            dv_cnt_ff  <= rvps_pkg::DivSteps;
            dv_busy_ff <= 1'b1;
            dv_is_r_ff <= 1'b0;
         end else if (cmd.div_step) begin
            // one restoring step: quotient bits shift into dv_num
            if (!dv_trial[48]) begin
               dv_rem_ff <= dv_trial[47:0];
               dv_num_ff <= {dv_num_ff[46:0], 1'b1};
            end else begin
               dv_rem_ff <= dv_rem_sh;
               dv_num_ff <= {dv_num_ff[46:0], 1'b0};
            end
            dv_cnt_ff <= dv_cnt_ff - 6'd1;
            if (dv_cnt_ff == 6'd1) dv_busy_ff <= 1'b0;
         end
         // collect quotient when a division finishes
         if (cmd.div_step && dv_cnt_ff == 6'd1) begin
            if (dv_is_r_ff) begin
               regime_ff <= r_neg_ff ? r_base_ff - dv_quot[18:0]
                                     : r_base_ff + dv_quot[18:0];
            end else begin
               vq_ff <= dv_quot;
            end
         end
         if (cmd.vclamp) vscale_ff <= vdiv_needed ? vclamped : 23'd65536;
         if (cmd.mult)   prod_ff   <= 42'(regime_ff) * 42'(vscale_ff);
         if (cmd.chg_a) begin
            mult_ff <= mult_sat;
            lhs_ff  <= {(mult_sat >= old_mult_ff) ? mult_sat - old_mult_ff
                                                   : old_mult_ff - mult_sat, 16'd0};
         end
         if (cmd.chg_b)  rhs_ff <= 56'(change_ratio_ff) * 56'(old_mult_ff);
         if (cmd.commit) begin
            changed_ff <= 56'(lhs_ff) > rhs_ff;
            upd_cnt_ff <= upd_cnt_ff + 32'd1;
            if (56'(lhs_ff) > rhs_ff) chg_cnt_ff <= chg_cnt_ff + 32'd1;
         end
      end
   end

   assign mult_out            = mult_ff;
   assign previous_multiplier = old_mult_ff;
   assign regime_out          = regime_ff;
   assign vol_scale_out       = vscale_ff;
   assign size_changed        = changed_ff;
   assign update_total        = upd_cnt_ff;
   assign change_total        = chg_cnt_ff;

   // counters move only on commit
   a_cnt_commit: assert property (@(posedge clock) disable iff (reset || csr_we)
      !$past(cmd.commit) && !$past(csr_we) && !$past(reset) |-> $stable(upd_cnt_ff))
      else $error("update count moved without commit");
   // change count steps together with the change flag
   a_chg_step: assert property (@(posedge clock) disable iff (reset || csr_we)
      $past(cmd.commit) && !$past(csr_we) && !$past(reset)
      |-> (chg_cnt_ff - $past(chg_cnt_ff)) == 32'(changed_ff))
      else $error("change count disagrees with flag");
   // divider only steps while busy
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> dv_busy_ff)
      else $error("divider step while idle");

endmodule

FILE: sim/testbench.sv
// Testbench for the regime and volatility position sizer core.
`timescale 1ns / 1ps
module testbench;

   localparam int StallLimit = 20000;
   localparam int Drain = 150;

   typedef struct {
      logic [24:0] mult;
      logic [24:0] prev;
      logic [18:0] regime;
      logic [22:0] vscale;
      logic        changed;
      logic [31:0] updates;
      logic [31:0] changes;
   } sizing_type;

   typedef struct {
      logic        cmd;
      logic [31:0] sample;
      logic        typed;   // row has a typed-in expected result
      sizing_type  want;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   regime_vol_position_sizer_core uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of registers and state
   logic [31:0] cfg [8];
   logic signed [31:0] hurst_q, vol_q;
   logic [31:0] mult_q, upd_q, chg_q;

   sizing_type sizing_q[$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int results_seen = 0;

   task automatic clear_sizer();
      hurst_q = rvps_pkg::QHalf;
      vol_q = 0;
      mult_q = rvps_pkg::QOne;
      upd_q = 0;
      chg_q = 0;
   endtask

   task automatic reset_registers();
      cfg[rvps_pkg::REG_HURST_CEILING] = 65536;
      cfg[rvps_pkg::REG_FACTOR_NEUTRAL] = 65536;
      cfg[rvps_pkg::REG_FACTOR_HIGH] = 98304;
      cfg[rvps_pkg::REG_FACTOR_LOW] = 32768;
      cfg[rvps_pkg::REG_VOL_TARGET] = 0;
      cfg[rvps_pkg::REG_VOL_FLOOR] = 16384;
      cfg[rvps_pkg::REG_VOL_CAP] = 131072;
      cfg[rvps_pkg::REG_CHANGE_RATIO] = 6554;
      clear_sizer();
   endtask

   // a + num*(b-a)/den, quotient truncated toward zero
   function automatic longint blend(longint a, longint b, longint num, longint den);
      longint diff;
      diff = b - a;
      if (diff >= 0) return a + (num * diff) / den;
      return a - (num * -diff) / den;
   endfunction

   function automatic longint regime_of(longint h);
      longint span;
      span = longint'(cfg[rvps_pkg::REG_HURST_CEILING]) - rvps_pkg::QHalf;
      if (h >= rvps_pkg::QHalf) begin
         if (span <= 0) return cfg[rvps_pkg::REG_FACTOR_NEUTRAL];
         if (h - rvps_pkg::QHalf >= span) return cfg[rvps_pkg::REG_FACTOR_HIGH];
         return blend(cfg[rvps_pkg::REG_FACTOR_NEUTRAL], cfg[rvps_pkg::REG_FACTOR_HIGH],
                      h - rvps_pkg::QHalf, span);
      end
      if (h <= 0) return cfg[rvps_pkg::REG_FACTOR_LOW];
      return blend(cfg[rvps_pkg::REG_FACTOR_LOW], cfg[rvps_pkg::REG_FACTOR_NEUTRAL],
                   h, rvps_pkg::QHalf);
   endfunction

   function automatic longint vscale_of();
      longint vf;
      if (vol_q <= 0 || cfg[rvps_pkg::REG_VOL_TARGET] == 0) return rvps_pkg::QOne;
      vf = (longint'(cfg[rvps_pkg::REG_VOL_TARGET]) << 16) / longint'(vol_q);
      if (vf > cfg[rvps_pkg::REG_VOL_CAP]) vf = cfg[rvps_pkg::REG_VOL_CAP];
      if (vf < cfg[rvps_pkg::REG_VOL_FLOOR]) vf = cfg[rvps_pkg::REG_VOL_FLOOR];
      return vf;
   endfunction

   // advance the sizer for one accepted item; returns 0 when it makes no result
   function automatic bit size_update(logic cmd, logic signed [31:0] s, output sizing_type r);
      longint rg, vs, prod, diff;
      logic [31:0] old;
      r = '{default: '0};
      if (cmd == rvps_pkg::CMD_VOL) begin
         if (s <= 0) return 0;
         vol_q = s;
      end else begin
         hurst_q = s;
      end
      old = mult_q;
      rg = regime_of(hurst_q);
      vs = vscale_of();
      prod = (rg * vs) >>> 16;
      if (prod > 33554431) prod = 33554431;
      mult_q = 32'(prod);
      upd_q++;
      diff = (mult_q >= old) ? mult_q - old : old - mult_q;
      r.changed = (diff << 16) > longint'(cfg[rvps_pkg::REG_CHANGE_RATIO]) * longint'(old);
      if (r.changed) chg_q++;
      r.mult = 25'(mult_q);
      r.prev = 25'(old);
      r.regime = 19'(rg);
      r.vscale = 23'(vs);
      r.updates = upd_q;
      r.changes = chg_q;
      return 1;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      sizing_type w;
      if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (sizing_q.size() == 0) begin
            report("unexpected result", 32'(results_seen), 32'd0);
         end else begin
            w = sizing_q.pop_front();
            if (rsp_tdata[24:0] != w.mult)
               report("multiplier", 32'(rsp_tdata[24:0]), 32'(w.mult));
            if (rsp_tdata[49:25] != w.prev)
               report("previous_multiplier", 32'(rsp_tdata[49:25]), 32'(w.prev));
            if (rsp_tdata[68:50] != w.regime)
               report("regime_out", 32'(rsp_tdata[68:50]), 32'(w.regime));
            if (rsp_tdata[91:69] != w.vscale)
               report("vol_scale_out", 32'(rsp_tdata[91:69]), 32'(w.vscale));
            if (rsp_tuser != w.changed)
               report("size_changed", 32'(rsp_tuser), 32'(w.changed));
            if (rsp_tdata[123:92] != w.updates)
               report("update_total", rsp_tdata[123:92], w.updates);
            if (rsp_tdata[155:124] != w.changes)
               report("change_total", rsp_tdata[155:124], w.changes);
         end
      end
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // send one item, with random sender gaps; valid stays up until the next gap
   task automatic send_sample(logic cmd, logic [31:0] s, bit typed, sizing_type want);
      sizing_type r;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      if (size_update(cmd, s, r)) begin
         if (typed) r = want;
         sizing_q.push_back(r);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sizing_q.size() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   task automatic write_reg(rvps_pkg::reg_index_type idx, logic [31:0] v);
      logic [31:0] masks [8];
      masks = '{32'h1FFFF, 32'h7FFFF, 32'h7FFFF, 32'h7FFFF,
                32'h7FFFFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFFFF};
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      cfg[idx] = v & masks[idx];
      clear_sizer();
   endtask

   function automatic logic [31:0] rand_sample(logic cmd);
      case ($urandom_range(9))
         0: return $urandom;
         1: return {1'($urandom_range(1)), 31'h0} | 32'($urandom_range(3));
         2, 3: return cmd ? $urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(30)
                          : $urandom_range(0, 90000);
         default: return cmd ? $urandom_range(1, 400000) : $urandom_range(0, 70000);
      endcase
   endfunction

   task automatic random_config();
      write_reg(rvps_pkg::REG_HURST_CEILING, $urandom_range(32769, 65536));
      write_reg(rvps_pkg::REG_FACTOR_NEUTRAL, $urandom_range(0, 262144));
      write_reg(rvps_pkg::REG_FACTOR_HIGH, $urandom_range(0, 262144));
      write_reg(rvps_pkg::REG_FACTOR_LOW, $urandom_range(0, 262144));
      write_reg(rvps_pkg::REG_VOL_TARGET,
                $urandom_range(3) == 0 ? 32'd0 : $urandom_range(1, 400000));
      write_reg(rvps_pkg::REG_VOL_FLOOR, $urandom_range(0, 100000));
      write_reg(rvps_pkg::REG_VOL_CAP, $urandom_range(0, 4194304));
      write_reg(rvps_pkg::REG_CHANGE_RATIO,
                $urandom_range(1) ? $urandom_range(0, 20000) : $urandom);
   endtask

   row_type rows [$];
   sizing_type none;

   initial begin
      logic c;
      reset_registers();
      none = '{default: '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers, hand values where obvious
      rows.push_back('{rvps_pkg::CMD_HURST, 32'd32768, 1,
                       '{65536, 65536, 65536, 65536, 0, 1, 0}});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'd65536, 1,
                       '{98304, 65536, 98304, 65536, 1, 2, 1}});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'h7FFFFFFF, 1,
                       '{98304, 98304, 98304, 65536, 0, 3, 1}});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'h80000000, 1,
                       '{32768, 98304, 32768, 65536, 1, 4, 2}});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'd0, 1,
                       '{32768, 32768, 32768, 65536, 0, 5, 2}});
      rows.push_back('{rvps_pkg::CMD_VOL, 32'd0, 0, none});
      rows.push_back('{rvps_pkg::CMD_VOL, 32'hFFFFFFFF, 0, none});
      rows.push_back('{rvps_pkg::CMD_VOL, 32'h80000000, 0, none});
      rows.push_back('{rvps_pkg::CMD_VOL, 32'h7FFFFFFF, 0, none});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'd16384, 0, none});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'd49152, 0, none});
      rows.push_back('{rvps_pkg::CMD_HURST, 32'd65535, 0, none});
      rows.push_back('{rvps_pkg::CMD_VOL, 32'd1, 0, none});
      foreach (rows[i]) send_sample(rows[i].cmd, rows[i].sample, rows[i].typed, rows[i].want);
      drain();

      // volatility scaling on, extremes of the clamps
      write_reg(rvps_pkg::REG_VOL_TARGET, 32'h7FFFFFFF);
      write_reg(rvps_pkg::REG_VOL_CAP, 4194304);
      write_reg(rvps_pkg::REG_VOL_FLOOR, 0);
      send_sample(rvps_pkg::CMD_VOL, 1, 0, none);
      send_sample(rvps_pkg::CMD_VOL, 32'h7FFFFFFF, 0, none);
      send_sample(rvps_pkg::CMD_VOL, 65536, 0, none);
      drain();
      write_reg(rvps_pkg::REG_VOL_FLOOR, 4194304);
      write_reg(rvps_pkg::REG_VOL_CAP, 0);
      write_reg(rvps_pkg::REG_CHANGE_RATIO, 0);
      send_sample(rvps_pkg::CMD_VOL, 3, 0, none);
      send_sample(rvps_pkg::CMD_HURST, 65536, 0, none);
      drain();
      write_reg(rvps_pkg::REG_FACTOR_NEUTRAL, 0);
      write_reg(rvps_pkg::REG_FACTOR_LOW, 0);
      write_reg(rvps_pkg::REG_FACTOR_HIGH, 262144);
      write_reg(rvps_pkg::REG_HURST_CEILING, 32769);
      write_reg(rvps_pkg::REG_CHANGE_RATIO, 32'h7FFFFFFF);
      write_reg(rvps_pkg::REG_VOL_TARGET, 0);
      send_sample(rvps_pkg::CMD_HURST, 0, 0, none);
      send_sample(rvps_pkg::CMD_HURST, 32768, 0, none);
      send_sample(rvps_pkg::CMD_HURST, 32769, 0, none);
      send_sample(rvps_pkg::CMD_HURST, 16384, 0, none);
      drain();

      // random phases over several settings and idling mixes
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_idle = 0; end
            1: begin send_idle = 80; recv_idle = 0; end
            2: begin send_idle = 0; recv_idle = 80; end
            default: begin send_idle = 11; recv_idle = 11; end
         endcase
         random_config();
         for (int n = 0; n < 125; n++) begin
            c = 1'($urandom_range(1));
            send_sample(c, rand_sample(c), 0, none);
         end
         drain();
      end

      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/rvps_pkg.sv
hw/rtl/rvps_ctrl.sv
hw/rtl/rvps_datapath.sv
hw/rtl/regime_vol_position_sizer_core.sv
sim/testbench.sv
